// ===== hw/rtl/kmedoids_swap_clustering_macros.svh =====
// assertion macros for the k-medoids swap clustering block
`ifndef KMEDOIDS_SWAP_CLUSTERING_MACROS_SVH
`define KMEDOIDS_SWAP_CLUSTERING_MACROS_SVH
`ifndef SYNTHESIS
`define KMSC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("kmsc assertion failed");
`define KMSC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("kmsc assertion failed");
`else
`define KMSC_ASSERT_IMP(label, clk, rst_n, a, c)
`define KMSC_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== hw/rtl/kmsc_pkg.sv =====
// shared constants and types of the k-medoids swap clustering block
package kmsc_pkg;
    localparam int MAX_POINTS   = 64;
    localparam int MAX_CLUSTERS = 16;
    localparam int DIST_BITS    = 24;
    localparam int PT_W         = $clog2(MAX_POINTS);
    localparam int SLOT_W       = $clog2(MAX_CLUSTERS);
    localparam int DADDR_W      = 2 * PT_W;
    localparam int DELTA_W      = DIST_BITS + PT_W + 4;
    localparam int DEV_W        = DIST_BITS + PT_W + 6;
    localparam int DEV_OUT_W    = 30;

    typedef enum logic [1:0] {
        FUNC_LOAD_DIST   = 2'd0,
        FUNC_LOAD_MEDOID = 2'd1,
        FUNC_START       = 2'd2,
        FUNC_NONE        = 2'd3
    } func_t;

    localparam logic CFG_NUM_POINTS   = 1'b0;
    localparam logic CFG_NUM_CLUSTERS = 1'b1;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [DIST_BITS-1:0] near;
        logic [DIST_BITS-1:0] sec;
    } point_rec_t;

    localparam int PREC_W = $bits(point_rec_t);
endpackage

// ===== hw/rtl/kmsc_ram.sv =====
// generic single-write, single-read ram with registered read data
module kmsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/kmedoids_swap_clustering.sv =====
// k-medoids swap clustering top level: loads, swap sweeps, per-point results
//
//   channel  signals                                  direction
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in
//   in       in_valid/in_ready, func .. medoid_point   in
//   out      out_valid/out_ready, point_index .. last  out
//
// load beats take one cycle each; in_ready is high only when idle
// start: a clamp state, then each refresh reads the distance ram port once per point and slot
// each candidate point sweeps all points, then scans the active slots; each taken swap adds a refresh
// results leave one at a time; the next is not read until out_ready takes the current one
// rst_n is asynchronous; stores come up unwritten, no clearing pass
`include "kmedoids_swap_clustering_macros.svh"
module kmedoids_swap_clustering
    import kmsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [6:0]             cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             func,
    input  logic [PT_W-1:0]        row_index,
    input  logic [PT_W-1:0]        col_index,
    input  logic [DIST_BITS-1:0]   distance,
    input  logic [SLOT_W-1:0]      medoid_slot,
    input  logic [PT_W-1:0]        medoid_point,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PT_W-1:0]        point_index,
    output logic [SLOT_W-1:0]      cluster_index,
    output logic                   is_medoid,
    output logic [DIST_BITS-1:0]   nearest_distance,
    output logic [DEV_OUT_W-1:0]   total_deviation,
    output logic                   last
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_CLAMP, ST_RF_RD, ST_RF_PROC, ST_SW_CHK, ST_SW_RD, ST_SW_PROC,
        ST_SB_INIT, ST_SB_CMP, ST_SB_DEC, ST_SW_NEXT, ST_O_RD, ST_O_LD, ST_O_WAIT
    } state_t;

    state_t state_reg;

    logic [6:0]                 num_points_reg;
    logic [4:0]                 num_clusters_reg;
    logic [PT_W-1:0]            n_last_reg;
    logic [SLOT_W-1:0]          k_last_reg;
    logic [PT_W-1:0]            p_reg;
    logic [PT_W-1:0]            c_reg;
    logic [SLOT_W-1:0]          s_reg;
    logic [SLOT_W-1:0]          best_reg;
    logic signed [DELTA_W-1:0]  bval_reg;
    logic signed [DELTA_W-1:0]  shared_reg;
    logic signed [DEV_W-1:0]    dev_reg;
    logic                       dev_mode_reg;
    logic                       improved_reg;
    logic [DIST_BITS:0]         near_reg;
    logic [DIST_BITS:0]         sec_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic [PT_W-1:0]            med_reg [MAX_CLUSTERS];
    logic signed [DELTA_W-1:0]  loss_reg [MAX_CLUSTERS];
    logic signed [DELTA_W-1:0]  delta_reg [MAX_CLUSTERS];

    logic                       dist_we;
    logic [DADDR_W-1:0]         dist_raddr;
    logic [DIST_BITS-1:0]       dist_rdata;
    logic                       pt_we;
    point_rec_t                 pt_wdata;
    point_rec_t                 pt_rd;
    logic [PREC_W-1:0]          pt_rdata;

    logic [PT_W-1:0]            med_pt;
    logic                       med_hit;
    logic [DIST_BITS:0]         d_ext;
    logic [DIST_BITS:0]         nn;
    logic [DIST_BITS:0]         ns;
    logic [SLOT_W-1:0]          nslot;
    logic signed [DELTA_W-1:0]  doj;
    logic signed [DELTA_W-1:0]  dn;
    logic signed [DELTA_W-1:0]  ds;
    logic signed [DELTA_W-1:0]  tot;
    logic [7:0]                 n_clamp;
    logic [7:0]                 k_clamp;
    logic                       in_beat;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_beat   = in_valid && in_ready;

    kmsc_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_POINTS * MAX_POINTS)) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr ({row_index, col_index}),
        .wdata (distance),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    kmsc_ram #(.WIDTH(PREC_W), .DEPTH(MAX_POINTS)) u_point_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (p_reg),
        .wdata (pt_wdata),
        .raddr (p_reg),
        .rdata (pt_rdata)
    );

    assign pt_rd   = point_rec_t'(pt_rdata);
    assign dist_we = in_beat && (func_t'(func) == FUNC_LOAD_DIST);

    always_comb
    begin
        if (state_reg == ST_SW_RD)
        begin
            dist_raddr = {p_reg, c_reg};
        end
        else
        begin
            dist_raddr = {p_reg, med_reg[s_reg]};
        end
    end

    // medoid test over active slots
    assign med_pt = (state_reg == ST_SW_CHK) ? c_reg : p_reg;
    always_comb
    begin
        med_hit = 1'b0;
        for (int i = 0; i < MAX_CLUSTERS; i++)
        begin
            if ((SLOT_W'(i) <= k_last_reg) && (med_reg[i] == med_pt))
            begin
                med_hit = 1'b1;
            end
        end
    end

    // nearest and second-nearest update for one slot
    assign d_ext = {1'b0, dist_rdata};
    always_comb
    begin
        nn    = near_reg;
        ns    = sec_reg;
        nslot = slot_reg;
        if (d_ext < sec_reg)
        begin
            if (d_ext < near_reg)
            begin
                ns    = near_reg;
                nn    = d_ext;
                nslot = s_reg;
            end
            else
            begin
                ns = d_ext;
            end
        end
    end

    assign pt_we          = (state_reg == ST_RF_PROC) && (s_reg == k_last_reg);
    assign pt_wdata.slot  = nslot;
    assign pt_wdata.near  = nn[DIST_BITS-1:0];
    assign pt_wdata.sec   = ns[DIST_BITS-1:0];

    assign doj = DELTA_W'(dist_rdata);
    assign dn  = DELTA_W'(pt_rd.near);
    assign ds  = DELTA_W'(pt_rd.sec);
    assign tot = bval_reg + shared_reg;

    always_comb
    begin
        n_clamp = {1'b0, num_points_reg};
        if (n_clamp < 8'd2)
        begin
            n_clamp = 8'd2;
        end
        if (n_clamp > 8'(MAX_POINTS))
        begin
            n_clamp = 8'(MAX_POINTS);
        end
        k_clamp = {3'b0, num_clusters_reg};
        if (k_clamp > 8'(MAX_CLUSTERS))
        begin
            k_clamp = 8'(MAX_CLUSTERS);
        end
        if (k_clamp > n_clamp)
        begin
            k_clamp = n_clamp;
        end
        if (k_clamp < 8'd2)
        begin
            k_clamp = 8'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            num_points_reg   <= 7'd64;
            num_clusters_reg <= 5'd2;
            out_valid        <= 1'b0;
            n_last_reg       <= '0;
            k_last_reg       <= '0;
            p_reg            <= '0;
            c_reg            <= '0;
            s_reg            <= '0;
            best_reg         <= '0;
            bval_reg         <= '0;
            shared_reg       <= '0;
            dev_mode_reg     <= 1'b0;
            improved_reg     <= 1'b0;
            dev_reg          <= '0;
            near_reg         <= {1'b1, {DIST_BITS{1'b0}}};
            sec_reg          <= {1'b1, {DIST_BITS{1'b0}}};
            slot_reg         <= '0;
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                med_reg[i]   <= '0;
                loss_reg[i]  <= '0;
                delta_reg[i] <= '0;
            end
            point_index      <= '0;
            cluster_index    <= '0;
            is_medoid        <= 1'b0;
            nearest_distance <= '0;
            last             <= 1'b0;
            total_deviation  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_NUM_POINTS:   num_points_reg   <= cfg_data;
                    CFG_NUM_CLUSTERS: num_clusters_reg <= cfg_data[4:0];
                    default:          num_points_reg   <= num_points_reg;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        unique case (func_t'(func))
                            FUNC_LOAD_MEDOID: med_reg[medoid_slot] <= medoid_point;
                            FUNC_START:
                            begin
                                n_last_reg <= PT_W'(n_clamp - 8'd1);
                                k_last_reg <= SLOT_W'(k_clamp - 8'd1);
                                state_reg  <= ST_CLAMP;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_CLAMP:
                begin
                    for (int i = 0; i < MAX_CLUSTERS; i++)
                    begin
                        if ((SLOT_W'(i) <= k_last_reg) && (med_reg[i] > n_last_reg))
                        begin
                            med_reg[i] <= n_last_reg;
                        end
                        loss_reg[i] <= '0;
                    end
                    dev_reg      <= '0;
                    dev_mode_reg <= 1'b1;
                    p_reg        <= '0;
                    s_reg        <= '0;
                    near_reg     <= {1'b1, {DIST_BITS{1'b0}}};
                    sec_reg      <= {1'b1, {DIST_BITS{1'b0}}};
                    slot_reg     <= '0;
                    state_reg    <= ST_RF_RD;
                end
                ST_RF_RD:
                begin
                    state_reg <= ST_RF_PROC;
                end
                ST_RF_PROC:
                begin
                    if (s_reg == k_last_reg)
                    begin
                        loss_reg[nslot] <= loss_reg[nslot] + DELTA_W'(ns - nn);
                        if (dev_mode_reg && !med_hit)
                        begin
                            dev_reg <= dev_reg + DEV_W'(nn);
                        end
                        near_reg <= {1'b1, {DIST_BITS{1'b0}}};
                        sec_reg  <= {1'b1, {DIST_BITS{1'b0}}};
                        slot_reg <= '0;
                        s_reg    <= '0;
                        if (p_reg == n_last_reg)
                        begin
                            if (dev_mode_reg)
                            begin
                                c_reg        <= '0;
                                improved_reg <= 1'b0;
                                dev_mode_reg <= 1'b0;
                                state_reg    <= ST_SW_CHK;
                            end
                            else
                            begin
                                state_reg <= ST_SW_NEXT;
                            end
                        end
                        else
                        begin
                            p_reg     <= p_reg + 1'b1;
                            state_reg <= ST_RF_RD;
                        end
                    end
                    else
                    begin
                        near_reg  <= nn;
                        sec_reg   <= ns;
                        slot_reg  <= nslot;
                        s_reg     <= s_reg + 1'b1;
                        state_reg <= ST_RF_RD;
                    end
                end
                ST_SW_CHK:
                begin
                    if (med_hit)
                    begin
                        state_reg <= ST_SW_NEXT;
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_CLUSTERS; i++)
                        begin
                            delta_reg[i] <= loss_reg[i];
                        end
                        shared_reg <= '0;
                        p_reg      <= '0;
                        state_reg  <= ST_SW_RD;
                    end
                end
                ST_SW_RD:
                begin
                    state_reg <= ST_SW_PROC;
                end
                ST_SW_PROC:
                begin
                    if (dist_rdata < pt_rd.near)
                    begin
                        shared_reg <= shared_reg + (doj - dn);
                        delta_reg[pt_rd.slot] <= delta_reg[pt_rd.slot] + (dn - ds);
                    end
                    else if (dist_rdata < pt_rd.sec)
                    begin
                        delta_reg[pt_rd.slot] <= delta_reg[pt_rd.slot] + (doj - ds);
                    end
                    if (p_reg == n_last_reg)
                    begin
                        state_reg <= ST_SB_INIT;
                    end
                    else
                    begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= ST_SW_RD;
                    end
                end
                ST_SB_INIT:
                begin
                    best_reg  <= '0;
                    bval_reg  <= delta_reg[0];
                    s_reg     <= SLOT_W'(1);
                    state_reg <= ST_SB_CMP;
                end
                ST_SB_CMP:
                begin
                    // first slot wins ties
                    if (delta_reg[s_reg] < bval_reg)
                    begin
                        best_reg <= s_reg;
                        bval_reg <= delta_reg[s_reg];
                    end
                    if (s_reg == k_last_reg)
                    begin
                        s_reg     <= '0;
                        state_reg <= ST_SB_DEC;
                    end
                    else
                    begin
                        s_reg <= s_reg + 1'b1;
                    end
                end
                ST_SB_DEC:
                begin
                    if (tot < 0)
                    begin
                        med_reg[best_reg] <= c_reg;
                        dev_reg           <= dev_reg + DEV_W'(tot);
                        improved_reg      <= 1'b1;
                        for (int i = 0; i < MAX_CLUSTERS; i++)
                        begin
                            loss_reg[i] <= '0;
                        end
                        p_reg     <= '0;
                        s_reg     <= '0;
                        near_reg  <= {1'b1, {DIST_BITS{1'b0}}};
                        sec_reg   <= {1'b1, {DIST_BITS{1'b0}}};
                        slot_reg  <= '0;
                        state_reg <= ST_RF_RD;
                    end
                    else
                    begin
                        state_reg <= ST_SW_NEXT;
                    end
                end
                ST_SW_NEXT:
                begin
                    if (c_reg == n_last_reg)
                    begin
                        if (!improved_reg || (dev_reg <= 0))
                        begin
                            if (dev_reg <= 0)
                            begin
                                total_deviation <= '0;
                            end
                            else if (dev_reg > DEV_W'({DEV_OUT_W{1'b1}}))
                            begin
                                total_deviation <= {DEV_OUT_W{1'b1}};
                            end
                            else
                            begin
                                total_deviation <= dev_reg[DEV_OUT_W-1:0];
                            end
                            p_reg     <= '0;
                            state_reg <= ST_O_RD;
                        end
                        else
                        begin
                            c_reg        <= '0;
                            improved_reg <= 1'b0;
                            state_reg    <= ST_SW_CHK;
                        end
                    end
                    else
                    begin
                        c_reg     <= c_reg + 1'b1;
                        state_reg <= ST_SW_CHK;
                    end
                end
                ST_O_RD:
                begin
                    state_reg <= ST_O_LD;
                end
                ST_O_LD:
                begin
                    point_index      <= p_reg;
                    cluster_index    <= pt_rd.slot;
                    nearest_distance <= pt_rd.near;
                    is_medoid        <= med_hit;
                    last             <= (p_reg == n_last_reg);
                    out_valid        <= 1'b1;
                    state_reg        <= ST_O_WAIT;
                end
                ST_O_WAIT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        if (last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            p_reg     <= p_reg + 1'b1;
                            state_reg <= ST_O_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `KMSC_ASSERT_IMP(a_ready_no_result, clk, rst_n, in_ready, !out_valid)
    `KMSC_ASSERT_IMP(a_slot_active, clk, rst_n, out_valid, cluster_index <= k_last_reg)
    `KMSC_ASSERT_IMP(a_last_point, clk, rst_n, out_valid && last, point_index == n_last_reg)
    `KMSC_ASSERT_NEXT(a_last_to_idle, clk, rst_n, out_valid && out_ready && last, in_ready)
endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the k-medoids swap clustering block
module tb_top;
    import kmsc_pkg::*;

    localparam longint DINF       = longint'(1) << DIST_BITS;
    localparam longint DEV_SAT    = 1073741823;
    localparam int     CYCLE_LIMIT = 4000000;
    localparam int     DRAIN_WAIT  = 40;
    localparam int     MAT_PTS     = 8;

    typedef struct {
        logic [1:0]           op;
        logic [PT_W-1:0]      row;
        logic [PT_W-1:0]      col;
        logic [DIST_BITS-1:0] dval;
        logic [SLOT_W-1:0]    slot;
        logic [PT_W-1:0]      mpoint;
    } load_item_t;

    typedef struct {
        logic [PT_W-1:0]      point;
        logic [SLOT_W-1:0]    cluster;
        logic                 medoid;
        logic [DIST_BITS-1:0] near;
        logic [DEV_OUT_W-1:0] dev;
        logic                 last;
    } assign_rec_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [6:0]           cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           func;
    logic [PT_W-1:0]      row_index;
    logic [PT_W-1:0]      col_index;
    logic [DIST_BITS-1:0] distance;
    logic [SLOT_W-1:0]    medoid_slot;
    logic [PT_W-1:0]      medoid_point;
    logic                 out_valid;
    logic                 out_ready;
    logic [PT_W-1:0]      point_index;
    logic [SLOT_W-1:0]    cluster_index;
    logic                 is_medoid;
    logic [DIST_BITS-1:0] nearest_distance;
    logic [DEV_OUT_W-1:0] total_deviation;
    logic                 last;

    kmedoids_swap_clustering i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .row_index        (row_index),
        .col_index        (col_index),
        .distance         (distance),
        .medoid_slot      (medoid_slot),
        .medoid_point     (medoid_point),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .point_index      (point_index),
        .cluster_index    (cluster_index),
        .is_medoid        (is_medoid),
        .nearest_distance (nearest_distance),
        .total_deviation  (total_deviation),
        .last             (last)
    );

    // shadow copy of the block state
    logic [DIST_BITS-1:0] dist_mem [MAX_POINTS*MAX_POINTS];
    logic [PT_W-1:0]      medoids [MAX_CLUSTERS];
    int                   near_slot [MAX_POINTS];
    longint               near_dist [MAX_POINTS];
    longint               sec_dist [MAX_POINTS];
    longint               removal [MAX_CLUSTERS];
    longint               delta [MAX_CLUSTERS];
    longint               exact_dev;
    logic [6:0]           reg_points;
    logic [6:0]           reg_clusters;

    load_item_t  pending_items [$];
    assign_rec_t expected_assigns [$];
    int          fail_count;
    int          cycle_count;
    bit          in_taken;
    bit          calm;
    int          in_gap;
    int          out_gap;

    function automatic bit is_medoid_pt(int p, int k);
        for (int s = 0; s < k; s++)
        begin
            if (medoids[s] == p)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void refresh_nearest(int n, int k);
        longint d;
        longint nr;
        longint sc;
        int     sl;
        for (int s = 0; s < k; s++)
            removal[s] = 0;
        for (int p = 0; p < n; p++)
        begin
            nr = DINF;
            sc = DINF;
            sl = 0;
            for (int s = 0; s < k; s++)
            begin
                d = dist_mem[p*MAX_POINTS + medoids[s]];
                if (d < sc)
                begin
                    if (d < nr)
                    begin
                        sc = nr;
                        nr = d;
                        sl = s;
                    end
                    else
                        sc = d;
                end
            end
            near_slot[p] = sl;
            near_dist[p] = nr;
            sec_dist[p]  = sc;
            removal[sl] += sc - nr;
        end
    endfunction

    function automatic void cluster_points(int n, int k);
        longint best_d;
        longint d;
        longint shared;
        longint doj;
        int     best;
        bit     improved;
        exact_dev = 0;
        for (int p = 0; p < n; p++)
        begin
            if (!is_medoid_pt(p, k))
            begin
                best_d = DINF;
                for (int s = 0; s < k; s++)
                begin
                    d = dist_mem[p*MAX_POINTS + medoids[s]];
                    if (d < best_d)
                        best_d = d;
                end
                exact_dev += best_d;
            end
        end
        refresh_nearest(n, k);
        forever
        begin
            improved = 1'b0;
            for (int c = 0; c < n; c++)
            begin
                if (!is_medoid_pt(c, k))
                begin
                    for (int s = 0; s < MAX_CLUSTERS; s++)
                        delta[s] = removal[s];
                    shared = 0;
                    for (int o = 0; o < n; o++)
                    begin
                        doj = dist_mem[o*MAX_POINTS + c];
                        if (doj < near_dist[o])
                        begin
                            shared += doj - near_dist[o];
                            delta[near_slot[o]] += near_dist[o] - sec_dist[o];
                        end
                        else if (doj < sec_dist[o])
                            delta[near_slot[o]] += doj - sec_dist[o];
                    end
                    best = 0;
                    for (int s = 1; s < k; s++)
                    begin
                        if (delta[s] < delta[best])
                            best = s;
                    end
                    delta[best] += shared;
                    if (delta[best] < 0)
                    begin
                        medoids[best] = PT_W'(c);
                        exact_dev += delta[best];
                        refresh_nearest(n, k);
                        improved = 1'b1;
                    end
                end
            end
            if (!improved || exact_dev <= 0)
                break;
        end
    endfunction

    function automatic void predict_assigns(load_item_t it);
        int          n;
        int          k;
        longint      dev;
        assign_rec_t rec;
        case (it.op)
            FUNC_LOAD_DIST:   dist_mem[it.row*MAX_POINTS + it.col] = it.dval;
            FUNC_LOAD_MEDOID: medoids[it.slot] = it.mpoint;
            FUNC_START:
            begin
                n = reg_points;
                if (n < 2)
                    n = 2;
                if (n > MAX_POINTS)
                    n = MAX_POINTS;
                k = reg_clusters;
                if (k > MAX_CLUSTERS)
                    k = MAX_CLUSTERS;
                if (k > n)
                    k = n;
                if (k < 2)
                    k = 2;
                for (int s = 0; s < k; s++)
                begin
                    if (medoids[s] >= n)
                        medoids[s] = PT_W'(n - 1);
                end
                cluster_points(n, k);
                dev = (exact_dev <= 0) ? 0 : (exact_dev > DEV_SAT ? DEV_SAT : exact_dev);
                for (int p = 0; p < n; p++)
                begin
                    rec.point   = PT_W'(p);
                    rec.cluster = SLOT_W'(near_slot[p]);
                    rec.medoid  = is_medoid_pt(p, k);
                    rec.near    = DIST_BITS'(near_dist[p]);
                    rec.dev     = DEV_OUT_W'(dev);
                    rec.last    = (p == n - 1);
                    expected_assigns = {expected_assigns, rec};
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DIST_BITS-1:0] rand_dist();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 6)
            return DIST_BITS'($urandom_range(0, 255));
        return DIST_BITS'($urandom);
    endfunction

    function automatic load_item_t rand_item();
        load_item_t it;
        int         r;
        r         = $urandom_range(0, 99);
        it.row    = PT_W'($urandom);
        it.col    = PT_W'($urandom);
        it.dval   = rand_dist();
        it.slot   = SLOT_W'($urandom);
        it.mpoint = PT_W'($urandom);
        if (r < 10)
            it.op = FUNC_START;
        else if (r < 60)
            it.op = FUNC_LOAD_DIST;
        else if (r < 85)
            it.op = FUNC_LOAD_MEDOID;
        else
            it.op = FUNC_NONE;
        return it;
    endfunction

    function automatic load_item_t make_item(logic [1:0] op, int a, int b, int v);
        load_item_t it;
        it.op     = op;
        it.row    = PT_W'(a);
        it.col    = PT_W'(b);
        it.dval   = DIST_BITS'(v);
        it.slot   = SLOT_W'(a);
        it.mpoint = PT_W'(b);
        return it;
    endfunction

    task automatic queue_item(load_item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_assigns.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_NUM_POINTS)
            reg_points = val;
        else
            reg_clusters = {2'b00, val[4:0]};
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(logic [6:0] np, logic [6:0] nc);
        wait_idle();
        write_reg(CFG_NUM_POINTS, np);
        write_reg(CFG_NUM_CLUSTERS, nc);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // sampling side: input beats feed the predictor, result beats are checked
    always @(posedge clk)
    begin
        assign_rec_t e;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && in_valid && in_ready)
        begin
            predict_assigns('{func, row_index, col_index, distance,
                              medoid_slot, medoid_point});
            in_taken = 1'b1;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_assigns.size() == 0)
            begin
                $error("unexpected result beat for point %0d", point_index);
                fail_count++;
            end
            else
            begin
                e = expected_assigns.pop_front();
                if (point_index !== e.point)
                begin
                    $error("point_index exp %0d got %0d", e.point, point_index);
                    fail_count++;
                end
                if (cluster_index !== e.cluster)
                begin
                    $error("cluster_index exp %0d got %0d", e.cluster, cluster_index);
                    fail_count++;
                end
                if (is_medoid !== e.medoid)
                begin
                    $error("is_medoid exp %0d got %0d", e.medoid, is_medoid);
                    fail_count++;
                end
                if (nearest_distance !== e.near)
                begin
                    $error("nearest_distance exp %0d got %0d", e.near, nearest_distance);
                    fail_count++;
                end
                if (total_deviation !== e.dev)
                begin
                    $error("total_deviation exp %0d got %0d", e.dev, total_deviation);
                    fail_count++;
                end
                if (last !== e.last)
                begin
                    $error("last exp %0d got %0d", e.last, last);
                    fail_count++;
                end
            end
        end
    end

    // input driver
    always @(negedge clk)
    begin
        load_item_t it;
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                func         <= it.op;
                row_index    <= it.row;
                col_index    <= it.col;
                distance     <= it.dval;
                medoid_slot  <= it.slot;
                medoid_point <= it.mpoint;
                in_valid     <= 1'b1;
                in_gap       = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap   = pick_gap();
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_NUM_POINTS;
        cfg_data     = '0;
        in_valid     = 1'b0;
        func         = FUNC_NONE;
        row_index    = '0;
        col_index    = '0;
        distance     = '0;
        medoid_slot  = '0;
        medoid_point = '0;
        out_ready    = 1'b0;
        fail_count   = 0;
        cycle_count  = 0;
        in_taken     = 1'b0;
        calm         = 1'b1;
        in_gap       = 0;
        out_gap      = 0;
        reg_points   = 7'd64;
        reg_clusters = 7'd2;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // small full matrix; point counts never exceed it so nothing read is unwritten
        set_sizes(7'(MAT_PTS), 7'd16);
        for (int r = 0; r < MAT_PTS; r++)
            for (int c = 0; c < MAT_PTS; c++)
                queue_item(make_item(FUNC_LOAD_DIST, r, c, rand_dist()));
        for (int s = 0; s < MAX_CLUSTERS; s++)
            queue_item(make_item(FUNC_LOAD_MEDOID, s, $urandom_range(0, 63), 0));
        queue_item(make_item(FUNC_LOAD_MEDOID, 15, 63, 0));
        queue_item(make_item(FUNC_LOAD_MEDOID, 14, 63, 0));
        queue_item(make_item(FUNC_NONE, 63, 63, 24'hFFFFFF));
        queue_item(make_item(FUNC_START, 0, 0, 0));
        calm = 1'b0;

        // smallest setting, registers below their clamp
        set_sizes(7'd0, 7'd0);
        queue_item(make_item(FUNC_START, 0, 0, 0));

        // zero deviation, medoid beyond n, duplicate medoids
        set_sizes(7'd4, 7'd31);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                queue_item(make_item(FUNC_LOAD_DIST, r, c, 0));
        queue_item(make_item(FUNC_LOAD_MEDOID, 0, 50, 0));
        queue_item(make_item(FUNC_LOAD_MEDOID, 1, 2, 0));
        queue_item(make_item(FUNC_LOAD_MEDOID, 2, 2, 0));
        queue_item(make_item(FUNC_START, 0, 0, 0));
        set_sizes(7'd4, 7'd2);
        queue_item(make_item(FUNC_START, 0, 0, 0));

        // random phases over small point counts
        for (int ph = 0; ph < 7; ph++)
        begin
            calm = (ph % 5 == 4);
            set_sizes(7'($urandom_range(0, MAT_PTS)), 7'($urandom_range(0, 31)));
            for (int i = 0; i < 15; i++)
                queue_item(rand_item());
            queue_item(make_item(FUNC_START, 0, 0, 0));
        end

        wait_idle();
        if (fail_count == 0 && expected_assigns.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
